@@ hw/rtl/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and codes of the protobuf field encoder.
// ----------------------------------------------------------------------------
package pfe_pkg;

    // item modes
    localparam logic [1:0] MODE_SCALAR  = 2'd0;
    localparam logic [1:0] MODE_BYTES   = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;
    localparam logic [1:0] MODE_NEW     = 2'd3;

    // wire types
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_SGROUP  = 3'd3;
    localparam logic [2:0] WT_EGROUP  = 3'd4;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FIELD = 2'd1;
    localparam logic [1:0] ST_WTYPE = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    localparam int          FRAME_BYTES = 15;
    localparam int          CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam logic [16:0] CNT_MAX     = 17'h1FFFF;
    localparam logic [15:0] BUF_RESET   = 16'd256;

    typedef struct packed {
        logic [1:0]  mode;
        logic [28:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic [7:0]  payload_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    // wire bytes of one item, byte 0 goes out first
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] data;
        logic [CNT_W-1:0]            count;
        logic [1:0]                  status;
    } t_frame;

endpackage

@@ hw/rtl/pfe_if.sv @@
// ----------------------------------------------------------------------------
// pfe_if
// Valid/ready channels of the encoder: input items and wire-byte results.
// ----------------------------------------------------------------------------
interface pfe_item_if;
    logic          valid;
    logic          ready;
    pfe_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pfe_result_if;
    logic            valid;
    logic            ready;
    pfe_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/protobuf_field_encoder.sv @@
// ----------------------------------------------------------------------------
// protobuf_field_encoder
// Protobuf wire-format field encoder, one wire byte per result transfer.
// ----------------------------------------------------------------------------
// Usage:
//   i_item   valid/ready channel of field items (scalar, bytes start,
//            payload byte, new message). A transfer lands in an input
//            register; the encoder turns it into up to 15 wire bytes
//            (key varint + value) held in a frame register.
//   o_result valid/ready channel of wire bytes with status and last.
//   i_cfg_we / i_cfg_data write buffer_size (write only while idle).
// Order: input register, then frame register, then output register.
// Throughput: one byte per cycle while o_result is not stalled, set by the
//   single output byte lane; an item holds the frame register until all
//   its bytes (up to 15) are sent. Items giving no bytes send no result. The
//   next item loads while the last byte of the previous one goes out.
// Reset (i_rst_n low, synchronous): channels empty, counters cleared,
//   buffer_size back to 256.
// Stall: when o_result.ready is low the output register holds its byte,
//   the frame stops and i_item.ready drops once the input register fills.
// ----------------------------------------------------------------------------
module protobuf_field_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfe_item_if.sink      i_item,
    pfe_result_if.source  o_result,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data
);
    import pfe_pkg::*;

    t_item  r_in;
    logic   r_in_v;
    logic   frame_free;
    logic   encode_go;
    t_frame frame;

    // the held item moves into the frame as soon as the frame can take it
    assign encode_go    = r_in_v && frame_free;
    assign i_item.ready = !r_in_v || encode_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_in   <= i_item.data;
                r_in_v <= 1'b1;
            end else if (encode_go) begin
                r_in_v <= 1'b0;
            end
        end
    end

    // key/value byte building and the byte and payload counters
    pfe_encode u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (encode_go),
        .i_item     (r_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_frame    (frame)
    );

    // frame register and output register
    pfe_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (encode_go),
        .i_frame  (frame),
        .o_free   (frame_free),
        .o_result (o_result)
    );

endmodule

@@ hw/rtl/pfe_encode.sv @@
// ----------------------------------------------------------------------------
// pfe_encode
// Builds the wire bytes of one item and keeps the byte and payload counters.
// ----------------------------------------------------------------------------
module pfe_encode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  pfe_pkg::t_item  i_item,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    output pfe_pkg::t_frame o_frame
);
    import pfe_pkg::*;

    logic [16:0] r_bw;
    logic [16:0] r_pr;
    logic [15:0] r_buf;
    logic [16:0] n_bw;
    logic [16:0] n_pr;

    logic [2:0]  kw;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [3:0]  vlen;
    logic        is_fixed;
    logic [7:0]  kb [5];
    logic [7:0]  vb [10];
    logic [3:0]  idx;
    logic [FRAME_BYTES-1:0][7:0] asm_data;
    logic        field_end;
    logic        count_it;
    logic [17:0] sum;

    function automatic logic [3:0] varint_len(input logic [63:0] v);
        logic [3:0] len;
        len = 4'd1;
        for (int g = 1; g < 10; g++) begin
            if ((v >> (7 * g)) != 64'd0) len = 4'(g + 1);
        end
        return len;
    endfunction

    function automatic logic [7:0] varint_byte(input logic [63:0] v, input int g);
        logic [63:0] t;
        t = v >> (7 * g);
        return {(t[63:7] != 57'd0), t[6:0]};
    endfunction

    function automatic logic field_bad(input logic [28:0] f);
        return (f == 29'd0) || ((f >= 29'd19000) && (f <= 29'd19999));
    endfunction

    always_comb begin
        kw       = (i_item.mode == MODE_BYTES) ? WT_LEN : i_item.wire_type;
        key      = {32'd0, i_item.field_number, kw};
        klen     = varint_len(key);
        is_fixed = (i_item.mode == MODE_SCALAR) &&
                   ((i_item.wire_type == WT_FIXED64) || (i_item.wire_type == WT_FIXED32));
        for (int g = 0; g < 5; g++) kb[g] = varint_byte(key, g);
        for (int g = 0; g < 10; g++) begin
            if (is_fixed) vb[g] = (g < 8) ? i_item.value[8*g +: 8] : 8'd0;
            else          vb[g] = varint_byte(i_item.value, g);
        end
        if (is_fixed) vlen = (i_item.wire_type == WT_FIXED64) ? 4'd8 : 4'd4;
        else          vlen = varint_len(i_item.value);

        // value bytes follow the key, shifted by the key length
        for (int j = 0; j < FRAME_BYTES; j++) begin
            idx = 4'(j) - klen;
            if ((j < 5) && (4'(j) < klen)) asm_data[j] = kb[j];
            else if (idx < 4'd10)          asm_data[j] = vb[idx];
            else                           asm_data[j] = 8'd0;
        end
    end

    always_comb begin
        o_frame.data   = asm_data;
        o_frame.count  = '0;
        o_frame.status = ST_OK;
        field_end      = 1'b1;
        count_it       = 1'b0;
        n_pr           = '0;
        n_bw           = r_bw;
        sum            = '0;

        unique case (i_item.mode)
            MODE_PAYLOAD: begin
                n_pr = r_pr;
                if (r_pr != 17'd0) begin
                    n_pr            = r_pr - 17'd1;
                    o_frame.data    = '0;
                    o_frame.data[0] = i_item.payload_byte;
                    o_frame.count   = CNT_W'(1);
                    field_end       = (r_pr == 17'd1);
                    count_it        = 1'b1;
                end
            end
            MODE_NEW: begin
                n_bw = '0;
            end
            MODE_BYTES: begin
                if (field_bad(i_item.field_number)) begin
                    o_frame.data   = '0;
                    o_frame.count  = CNT_W'(1);
                    o_frame.status = ST_FIELD;
                end else begin
                    o_frame.count = klen + vlen;
                    n_pr          = (i_item.value > 64'(CNT_MAX)) ? CNT_MAX
                                                                  : i_item.value[16:0];
                    field_end     = (i_item.value == 64'd0);
                    count_it      = 1'b1;
                end
            end
            MODE_SCALAR: begin
                priority if ((i_item.wire_type > WT_FIXED32) ||
                             (i_item.wire_type == WT_LEN)) begin
                    o_frame.data   = '0;
                    o_frame.count  = CNT_W'(1);
                    o_frame.status = ST_WTYPE;
                end else if ((i_item.wire_type == WT_SGROUP) ||
                             (i_item.wire_type == WT_EGROUP)) begin
                    o_frame.count = '0;
                end else if ((i_item.wire_type == WT_VARINT) &&
                             (i_item.value == 64'd0)) begin
                    o_frame.count = '0;
                end else if (field_bad(i_item.field_number)) begin
                    o_frame.data   = '0;
                    o_frame.count  = CNT_W'(1);
                    o_frame.status = ST_FIELD;
                end else begin
                    o_frame.count = klen + vlen;
                    count_it      = 1'b1;
                end
            end
        endcase

        if (count_it) begin
            sum  = {1'b0, r_bw} + 18'(o_frame.count);
            n_bw = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[16:0];
            if (field_end && (n_bw >= {1'b0, r_buf})) o_frame.status = ST_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw  <= '0;
            r_pr  <= '0;
            r_buf <= BUF_RESET;
        end else begin
            if (i_go) begin
                r_bw <= n_bw;
                r_pr <= n_pr;
            end
            if (i_cfg_we) r_buf <= i_cfg_data;
        end
    end

endmodule

@@ hw/rtl/pfe_serial.sv @@
// ----------------------------------------------------------------------------
// pfe_serial
// Frame register and output register: sends one wire byte per transfer.
// ----------------------------------------------------------------------------
module pfe_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  pfe_pkg::t_frame i_frame,
    output logic            o_free,
    pfe_result_if.source    o_result
);
    import pfe_pkg::*;

    logic [FRAME_BYTES-1:0][7:0] r_data;
    logic [CNT_W-1:0]            r_cnt;
    logic [1:0]                  r_st;
    logic                        r_out_v;
    t_result                     r_out;
    logic                        out_load;

    assign out_load = (r_cnt != '0) && (!r_out_v || o_result.ready);
    // frame empties this cycle: the next item may load behind its last byte
    assign o_free   = (r_cnt == '0) || (out_load && (r_cnt == CNT_W'(1)));

    assign o_result.valid = r_out_v;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_load) begin
                r_data <= i_frame.data;
                r_cnt  <= i_frame.count;
                r_st   <= i_frame.status;
            end else if (out_load) begin
                r_data <= r_data >> 8;
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            if (out_load) begin
                r_out_v        <= 1'b1;
                r_out.out_byte <= r_data[0];
                r_out.last     <= (r_cnt == CNT_W'(1));
                r_out.status   <= (r_cnt == CNT_W'(1)) ? r_st : ST_OK;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("frame loaded while bytes still pending");
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_cnt == CNT_W'(1)) && !i_load) |=> (r_cnt == '0))
        else $error("frame not empty after its last byte");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FRAME_BYTES))
        else $error("frame byte count out of range");
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.last) |-> (r_out.status == ST_OK))
        else $error("status on a byte that is not last");
`endif

endmodule
